@@ sv/dd_mix_pkg.sv @@
// dd_mix_pkg: widths, codes, the pipeline control struct and the divider step
// shared by the differential drive mixer top level and its lane datapath
// no dependencies
package dd_mix_pkg;

    localparam int unsigned DataW     = 8;
    localparam int unsigned PivotW    = 7;
    localparam int unsigned NumStages = 5;
    localparam int unsigned ProdW     = 16;
    localparam int unsigned NumW      = 24;
    localparam int unsigned MagW      = 16;
    localparam int unsigned QuotW     = 7;

    localparam logic [PivotW-1:0]     PivotReset = 7'd32;
    localparam logic signed [DataW:0] QuadFull   = 9'sd127;

    localparam logic SideLeft  = 1'b0;
    localparam logic SideRight = 1'b1;

    typedef struct packed {
        logic [NumStages-1:0] adv;
    } t_pipe_ctl;

    typedef struct packed {
        logic            q;
        logic [MagW-1:0] rem;
    } t_div_step;

    function automatic t_div_step div_step(input logic [MagW-1:0] rem,
                                           input logic [MagW-1:0] dsh);
        t_div_step r;
        r.q   = (rem >= dsh);
        r.rem = r.q ? (rem - dsh) : rem;
        return r;
    endfunction

endpackage

@@ sv/differential_drive_joystick_mixer.sv @@
// Differential drive joystick mixer with pivot blending. One joystick sample
// (turn, throttle) is taken per clock while o_stall is low, and the left and
// right drive values come out at one result per clock while the output is not
// stalled. The five register stages are premix and throttle product, blend
// products, blend sum and magnitude, then two restoring divide stages by the
// pivot limit (or by one when not blending) that also truncate toward zero and
// saturate to -128..127. A stall on the output only holds the pipeline once
// every stage is full, so empty stages keep filling. The pivot limit resets to
// 32; write it only while no transfer is in flight.
// depends on dd_mix_pkg and dd_mix_lane
module differential_drive_joystick_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [dd_mix_pkg::PivotW-1:0]       i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [dd_mix_pkg::DataW-1:0] i_turn_command,
    input  logic signed [dd_mix_pkg::DataW-1:0] i_throttle_command,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [dd_mix_pkg::DataW-1:0] o_left_drive,
    output logic signed [dd_mix_pkg::DataW-1:0] o_right_drive
);

    logic [dd_mix_pkg::PivotW-1:0]    r_pivot_limit;
    logic [dd_mix_pkg::NumStages-1:0] r_valid;
    logic [dd_mix_pkg::NumStages-1:0] n_valid;
    dd_mix_pkg::t_pipe_ctl            ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot_limit <= dd_mix_pkg::PivotReset;
        end else if (i_cfg_wr_en) begin
            r_pivot_limit <= i_cfg_wr_data;
        end
    end

    // a stage moves on when empty or when the next one moves
    always_comb begin
        ctl.adv[dd_mix_pkg::NumStages-1] = !r_valid[dd_mix_pkg::NumStages-1] || !i_stall;
        for (int k = dd_mix_pkg::NumStages - 2; k >= 0; k--) begin
            ctl.adv[k] = !r_valid[k] || ctl.adv[k+1];
        end
        n_valid[0] = ctl.adv[0] ? i_valid : r_valid[0];
        for (int k = 1; k < dd_mix_pkg::NumStages; k++) begin
            n_valid[k] = ctl.adv[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall = !ctl.adv[0];
    assign o_valid = r_valid[dd_mix_pkg::NumStages-1];

    dd_mix_lane u_left (
        .i_clk   (i_clk),
        .i_side  (dd_mix_pkg::SideLeft),
        .i_ctl   (ctl),
        .i_x     (i_turn_command),
        .i_y     (i_throttle_command),
        .i_pivot (r_pivot_limit),
        .o_drive (o_left_drive)
    );

    dd_mix_lane u_right (
        .i_clk   (i_clk),
        .i_side  (dd_mix_pkg::SideRight),
        .i_ctl   (ctl),
        .i_x     (i_turn_command),
        .i_y     (i_throttle_command),
        .i_pivot (r_pivot_limit),
        .o_drive (o_right_drive)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_valid))
        else $error("input stalled with an empty stage");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> o_valid)
        else $error("transfer did not reach the output in five cycles");

endmodule

@@ sv/dd_mix_lane.sv @@
// dd_mix_lane: five-stage datapath for one motor side (premix, products,
// blend sum, two restoring divide stages with saturation)
// depends on dd_mix_pkg; stage advance comes from the top level
module dd_mix_lane (
    input  logic                                i_clk,
    input  logic                                i_side,
    input  dd_mix_pkg::t_pipe_ctl               i_ctl,
    input  logic signed [dd_mix_pkg::DataW-1:0] i_x,
    input  logic signed [dd_mix_pkg::DataW-1:0] i_y,
    input  logic [dd_mix_pkg::PivotW-1:0]       i_pivot,
    output logic signed [dd_mix_pkg::DataW-1:0] o_drive
);

    // stage 1: premix, throttle product, blend decision
    logic [7:0]         n1_absx;
    logic [7:0]         n1_absy;
    logic               n1_reduce;
    logic signed [8:0]  n1_prem;
    logic signed [16:0] n1_prod;
    logic               n1_blend;

    logic signed [7:0]  r1_x;
    logic [7:0]         r1_a;
    logic [6:0]         r1_pma;
    logic [6:0]         r1_d;
    logic               r1_blend;
    logic signed [15:0] r1_py;

    always_comb begin
        n1_absx   = i_x[7] ? (~$unsigned(i_x) + 8'd1) : $unsigned(i_x);
        n1_absy   = i_y[7] ? (~$unsigned(i_y) + 8'd1) : $unsigned(i_y);
        n1_reduce = (i_side == dd_mix_pkg::SideLeft) ? (i_x[7] ^ i_y[7])
                                                     : ~(i_x[7] ^ i_y[7]);
        n1_prem   = n1_reduce ? (dd_mix_pkg::QuadFull - $signed({1'b0, n1_absx}))
                              : dd_mix_pkg::QuadFull;
        n1_prod   = n1_prem * i_y;
        n1_blend  = (i_pivot != 7'd0) && ({1'b0, i_pivot} >= n1_absy);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r1_x     <= i_x;
            r1_a     <= n1_absy;
            r1_pma   <= i_pivot - n1_absy[6:0];
            r1_d     <= n1_blend ? i_pivot : 7'd1;
            r1_blend <= n1_blend;
            r1_py    <= n1_prod[15:0];
        end
    end

    // stage 2: blend products
    logic signed [24:0] n2_apy;
    logic signed [15:0] n2_w;

    logic signed [23:0] r2_apy;
    logic signed [15:0] r2_w;
    logic signed [15:0] r2_py;
    logic [6:0]         r2_d;
    logic               r2_blend;

    always_comb begin
        n2_apy = $signed({1'b0, r1_a}) * r1_py;
        n2_w   = $signed({1'b0, r1_pma}) * r1_x;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[1]) begin
            r2_apy   <= n2_apy[23:0];
            r2_w     <= n2_w;
            r2_py    <= r1_py;
            r2_d     <= r1_d;
            r2_blend <= r1_blend;
        end
    end

    // stage 3: numerator, sign and magnitude over 128
    logic signed [23:0] n3_wext;
    logic signed [23:0] n3_sterm;
    logic signed [23:0] n3_num;
    logic [23:0]        n3_abs;

    logic               r3_neg;
    logic [15:0]        r3_m;
    logic [6:0]         r3_d;

    always_comb begin
        n3_wext  = 24'(r2_w);
        n3_sterm = (i_side == dd_mix_pkg::SideRight) ? -n3_wext : n3_wext;
        n3_num   = r2_blend ? (r2_apy + (n3_sterm <<< 7)) : 24'(r2_py);
        n3_abs   = n3_num[23] ? $unsigned(-n3_num) : $unsigned(n3_num);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[2]) begin
            r3_neg <= n3_num[23];
            r3_m   <= n3_abs[22:7];
            r3_d   <= r2_d;
        end
    end

    // stage 4: overflow check and upper quotient bits
    dd_mix_pkg::t_div_step n4_st;
    logic [15:0]           n4_rem;
    logic [2:0]            n4_q;
    logic                  n4_sat;

    logic                  r4_neg;
    logic                  r4_sat;
    logic [2:0]            r4_q;
    logic [15:0]           r4_rem;
    logic [6:0]            r4_d;

    always_comb begin
        n4_sat = (r3_m >= (16'(r3_d) << 7));
        n4_rem = r3_m;
        n4_q   = 3'd0;
        for (int i = 2; i >= 0; i--) begin
            n4_st   = dd_mix_pkg::div_step(n4_rem, 16'(r3_d) << (i + 4));
            n4_q[i] = n4_st.q;
            n4_rem  = n4_st.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[3]) begin
            r4_neg <= r3_neg;
            r4_sat <= n4_sat;
            r4_q   <= n4_q;
            r4_rem <= n4_rem;
            r4_d   <= r3_d;
        end
    end

    // stage 5: lower quotient bits, sign and saturation
    dd_mix_pkg::t_div_step n5_st;
    logic [15:0]           n5_rem;
    logic [3:0]            n5_q;
    logic [7:0]            n5_mag;
    logic signed [7:0]     n5_drive;

    logic signed [7:0]     r5_drive;

    always_comb begin
        n5_rem = r4_rem;
        n5_q   = 4'd0;
        for (int i = 3; i >= 0; i--) begin
            n5_st   = dd_mix_pkg::div_step(n5_rem, 16'(r4_d) << i);
            n5_q[i] = n5_st.q;
            n5_rem  = n5_st.rem;
        end
        n5_mag = {1'b0, r4_q, n5_q};
        if (r4_sat) begin
            n5_drive = r4_neg ? 8'sh80 : 8'sh7f;
        end else begin
            n5_drive = r4_neg ? $signed(~n5_mag + 8'd1) : $signed(n5_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[4]) begin
            r5_drive <= n5_drive;
        end
    end

    assign o_drive = r5_drive;

endmodule
